>>> sv/sdspi_pkg.sv
// shared types, command codes and crc helper for the sd card spi slave
package sdspi_pkg;

    localparam int SECTOR_BYTES_C = 512;
    localparam int CSD_BYTES_C    = 16;

    localparam logic [31:0] OCR_VALUE   = 32'hC0FF_FF00;
    localparam logic [7:0]  FILL_BYTE   = 8'hFF;
    localparam logic [7:0]  TOKEN_START = 8'hFE;
    localparam logic [7:0]  TOKEN_WR    = 8'hFC;
    localparam logic [7:0]  TOKEN_STOP  = 8'hFD;
    localparam logic [7:0]  DATA_ACCEPT = 8'h05;
    localparam logic [7:0]  CSD_BYTE0   = 8'h40;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;

    // command bytes as seen on mosi
    localparam logic [7:0] CMD0    = 8'h40;
    localparam logic [7:0] CMD8    = 8'h48;
    localparam logic [7:0] CMD9    = 8'h49;
    localparam logic [7:0] CMD12   = 8'h4C;
    localparam logic [7:0] CMD18   = 8'h52;
    localparam logic [7:0] CMD25   = 8'h59;
    localparam logic [7:0] ACMD41  = 8'h69;
    localparam logic [7:0] CMD55   = 8'h77;
    localparam logic [7:0] CMD58   = 8'h7A;
    localparam logic [7:0] CMD59   = 8'h7B;

    typedef enum logic [1:0] {
        OP_SPI  = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2,
        OP_BEGIN = 2'd3
    } op_t;

    localparam int NUM_ST = 34;

    typedef enum logic [NUM_ST-1:0] {
        ST_IDLE     = (34'd1 << 0),
        ST_ARG0     = (34'd1 << 1),
        ST_ARG1     = (34'd1 << 2),
        ST_ARG2     = (34'd1 << 3),
        ST_ARG3     = (34'd1 << 4),
        ST_CRC      = (34'd1 << 5),
        ST_R1_IDLE  = (34'd1 << 6),
        ST_R1_SEND  = (34'd1 << 7),
        ST_ECHO_GAP = (34'd1 << 8),
        ST_ECHO_R1  = (34'd1 << 9),
        ST_ECHO_B3  = (34'd1 << 10),
        ST_ECHO_B2  = (34'd1 << 11),
        ST_ECHO_B1  = (34'd1 << 12),
        ST_ECHO_B0  = (34'd1 << 13),
        ST_R1_READY = (34'd1 << 14),
        ST_OCR      = (34'd1 << 15),
        ST_CSD_GAP  = (34'd1 << 16),
        ST_CSD_R1   = (34'd1 << 17),
        ST_CSD_TOK  = (34'd1 << 18),
        ST_CSD_BODY = (34'd1 << 19),
        ST_CRC_HI   = (34'd1 << 20),
        ST_CRC_LO   = (34'd1 << 21),
        ST_RD_GAP   = (34'd1 << 22),
        ST_RD_R1    = (34'd1 << 23),
        ST_RD_TOK   = (34'd1 << 24),
        ST_RD_BODY  = (34'd1 << 25),
        ST_WR_GAP   = (34'd1 << 26),
        ST_WR_R1    = (34'd1 << 27),
        ST_WR_TOK   = (34'd1 << 28),
        ST_WR_BODY  = (34'd1 << 29),
        ST_WR_CRC0  = (34'd1 << 30),
        ST_WR_CRC1  = (34'd1 << 31),
        ST_WR_ACK   = (34'd1 << 32),
        ST_WR_STOP  = (34'd1 << 33)
    } state_t;

    // crc-16 ccitt, poly 0x1021, msb first, one byte
    function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ 16'h1021;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

>>> sv/sd_card_spi_slave_top.sv
// sd card spi mode slave, card side, one exchanged byte per transfer
//
// input channel s_*: one transfer per spi byte or host buffer op; s_tuser
// carries the op (exchange, load buffer, read buffer, begin transaction),
// s_tdata the mosi byte, buffer index and buffer data
// result channel m_*: exactly one transfer per input transfer, in order,
// carrying miso byte, read/write request, block number, buffer byte and
// the unknown command flag
// card_sectors_we / card_sectors_wdata: sector count reported in the csd
// result timing: a result is registered and becomes valid in the cycle after its input transfer
// throughput: one transfer per cycle while results are taken; the sector buffer is a 512 x 8
// single write, single read memory with registered read data, and the
// state update for each byte is a single pass between two registers
// reset (aresetn low, synchronous): protocol back to idle, counters and
// crc cleared, card_sectors back to 1048576; the buffer is not cleared
// stall: while m_tready is low the result holds and s_tready drops once
// the result register is full; nothing is lost or repeated
module sd_card_spi_slave_top
    import sdspi_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_C
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] spi_in, [16:8] buf_index, [24:17] buf_data, rest zero
    input  logic [31:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] spi_out, [8] read_request, [9] write_request,
    // [41:10] block_number, [49:42] buffer_byte, [50] unknown_command
    output logic [55:0] m_tdata,
    input  logic        card_sectors_we,
    input  logic [31:0] card_sectors_wdata
);

    localparam int AW = $clog2(SECTOR_BYTES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] SECT_END = CW'(SECTOR_BYTES);
    localparam logic [CW-1:0] CSD_END  = CW'(CSD_BYTES_C);

    // unpack the input transfer
    op_t          in_op;
    logic [7:0]   spi_in;
    logic [8:0]   buf_index;
    logic [7:0]   buf_data;

    assign in_op     = op_t'(s_tuser);
    assign spi_in    = s_tdata[7:0];
    assign buf_index = s_tdata[16:8];
    assign buf_data  = s_tdata[24:17];

    logic s_accept;

    // protocol state
    state_t       state_reg, state_next;
    state_t       after_reg, after_next;
    logic [31:0]  arg_reg, arg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]  crc_reg, crc_next;
    logic         crc_pend_reg, crc_pend_next;
    logic [31:0]  card_sectors_reg;

    // sector buffer
    logic [7:0]   mem [SECTOR_BYTES];
    logic [7:0]   mem_q_reg;
    logic         mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]   mem_wdata;

    // result register
    logic         out_valid_reg;
    logic [7:0]   spi_reg, spi_next;
    logic         spi_mem_reg, spi_mem_next;
    logic         rd_reg, rd_next;
    logic         wr_reg, wr_next;
    logic [31:0]  blk_reg;
    logic         bb_sel_reg, bb_sel_next;
    logic         unk_reg, unk_next;

    logic [15:0]  crc_eff;
    logic [CW-1:0] cnt_inc;
    logic [31:0]  csd_n;
    logic [7:0]   csd_val;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // a read byte from the buffer still has to be folded into the crc
    assign crc_eff = crc_pend_reg ? crc_add(crc_reg, mem_q_reg) : crc_reg;
    assign cnt_inc = cnt_reg + CW'(1);
    assign csd_n   = {10'd0, card_sectors_reg[31:10]} - 32'd1;

    always_comb begin
        case (cnt_reg)
            CW'(0):  csd_val = CSD_BYTE0;
            CW'(7):  csd_val = csd_n[23:16];
            CW'(8):  csd_val = csd_n[15:8];
            CW'(9):  csd_val = csd_n[7:0];
            default: csd_val = 8'h00;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        after_next    = after_reg;
        arg_next      = arg_reg;
        cnt_next      = cnt_reg;
        crc_next      = crc_eff;
        crc_pend_next = 1'b0;
        spi_next      = FILL_BYTE;
        spi_mem_next  = 1'b0;
        rd_next       = 1'b0;
        wr_next       = 1'b0;
        bb_sel_next   = 1'b0;
        unk_next      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = buf_index[AW-1:0];
        mem_wdata     = buf_data;
        mem_raddr     = buf_index[AW-1:0];

        case (in_op)
            OP_LOAD: begin
                mem_we = 1'b1;
            end
            OP_READ: begin
                mem_re      = 1'b1;
                bb_sel_next = 1'b1;
            end
            OP_BEGIN: begin
                state_next = ST_IDLE;
            end
            default: begin
                case (state_reg)
                    ST_IDLE: begin
                        case (spi_in)
                            FILL_BYTE: ;
                            CMD0, CMD59, CMD55: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_R1_IDLE;
                            end
                            CMD8: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_ECHO_GAP;
                            end
                            CMD12, ACMD41: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_R1_READY;
                            end
                            CMD58: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_OCR;
                            end
                            CMD9: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_CSD_GAP;
                            end
                            CMD18: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_RD_GAP;
                            end
                            CMD25: begin
                                state_next = ST_ARG0; arg_next = '0; after_next = ST_WR_GAP;
                            end
                            default: unk_next = 1'b1;
                        endcase
                    end
                    ST_ARG0: begin arg_next = {24'd0, spi_in}; state_next = ST_ARG1; end
                    ST_ARG1: begin arg_next = {arg_reg[23:0], spi_in}; state_next = ST_ARG2; end
                    ST_ARG2: begin arg_next = {arg_reg[23:0], spi_in}; state_next = ST_ARG3; end
                    ST_ARG3: begin arg_next = {arg_reg[23:0], spi_in}; state_next = ST_CRC; end
                    ST_CRC:      state_next = after_reg;
                    ST_R1_IDLE:  begin arg_next = {24'd0, R1_IDLE}; state_next = ST_R1_SEND; end
                    ST_R1_READY: begin arg_next = {24'd0, R1_READY}; state_next = ST_R1_SEND; end
                    ST_R1_SEND:  begin spi_next = arg_reg[7:0]; state_next = ST_IDLE; end
                    ST_ECHO_GAP: state_next = ST_ECHO_R1;
                    ST_OCR:      begin arg_next = OCR_VALUE; state_next = ST_ECHO_R1; end
                    ST_ECHO_R1:  begin spi_next = 8'h00; state_next = ST_ECHO_B3; end
                    ST_ECHO_B3:  begin spi_next = arg_reg[31:24]; state_next = ST_ECHO_B2; end
                    ST_ECHO_B2:  begin spi_next = arg_reg[23:16]; state_next = ST_ECHO_B1; end
                    ST_ECHO_B1:  begin spi_next = arg_reg[15:8]; state_next = ST_ECHO_B0; end
                    ST_ECHO_B0:  begin spi_next = arg_reg[7:0]; state_next = ST_IDLE; end
                    ST_CSD_GAP: begin
                        cnt_next = '0; crc_next = '0; state_next = ST_CSD_R1;
                    end
                    ST_CSD_R1:  begin spi_next = 8'h00; state_next = ST_CSD_TOK; end
                    ST_CSD_TOK: begin spi_next = TOKEN_START; state_next = ST_CSD_BODY; end
                    ST_CSD_BODY: begin
                        spi_next = csd_val;
                        crc_next = crc_add(crc_eff, csd_val);
                        cnt_next = cnt_inc;
                        if (cnt_inc >= CSD_END) begin
                            state_next = ST_CRC_HI;
                        end
                    end
                    ST_CRC_HI: begin spi_next = crc_eff[15:8]; state_next = ST_CRC_LO; end
                    ST_CRC_LO: begin spi_next = crc_eff[7:0]; state_next = ST_IDLE; end
                    ST_RD_GAP: state_next = ST_RD_R1;
                    ST_RD_R1:  begin spi_next = 8'h00; state_next = ST_RD_TOK; end
                    ST_RD_TOK: begin
                        rd_next    = 1'b1;
                        spi_next   = TOKEN_START;
                        cnt_next   = '0;
                        crc_next   = '0;
                        state_next = ST_RD_BODY;
                    end
                    ST_RD_BODY: begin
                        // byte arrives from the memory next cycle, crc folds it then
                        mem_re        = 1'b1;
                        mem_raddr     = cnt_reg[AW-1:0];
                        spi_mem_next  = 1'b1;
                        crc_pend_next = 1'b1;
                        cnt_next      = cnt_inc;
                        if (cnt_inc >= SECT_END) begin
                            state_next = ST_CRC_HI;
                        end
                    end
                    ST_WR_GAP: state_next = ST_WR_R1;
                    ST_WR_R1:  begin spi_next = 8'h00; cnt_next = '0; state_next = ST_WR_TOK; end
                    ST_WR_TOK: begin
                        if (spi_in == TOKEN_WR) begin
                            state_next = ST_WR_BODY;
                        end
                    end
                    ST_WR_BODY: begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_reg[AW-1:0];
                        mem_wdata = spi_in;
                        cnt_next  = cnt_inc;
                        if (cnt_inc >= SECT_END) begin
                            state_next = ST_WR_CRC0;
                        end
                    end
                    ST_WR_CRC0: state_next = ST_WR_CRC1;
                    ST_WR_CRC1: state_next = ST_WR_ACK;
                    ST_WR_ACK: begin
                        wr_next = 1'b1; spi_next = DATA_ACCEPT; state_next = ST_WR_STOP;
                    end
                    ST_WR_STOP: begin
                        if (spi_in == TOKEN_STOP) begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
        endcase
    end

    // sector buffer, one write and one registered read per cycle, only on an accepted transfer
    always_ff @(posedge aclk) begin
        if (s_accept && mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept && mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            after_reg        <= ST_IDLE;
            arg_reg          <= '0;
            cnt_reg          <= '0;
            crc_reg          <= '0;
            crc_pend_reg     <= 1'b0;
            card_sectors_reg <= 32'd1048576;
            out_valid_reg    <= 1'b0;
        end else begin
            if (card_sectors_we) begin
                card_sectors_reg <= card_sectors_wdata;
            end
            if (s_accept) begin
                state_reg     <= state_next;
                after_reg     <= after_next;
                arg_reg       <= arg_next;
                cnt_reg       <= cnt_next;
                crc_reg       <= crc_next;
                crc_pend_reg  <= crc_pend_next;
                out_valid_reg <= 1'b1;
            end else begin
                crc_reg      <= crc_eff;
                crc_pend_reg <= 1'b0;
                if (m_tready) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // result payload, loaded with each input transfer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            spi_reg     <= spi_next;
            spi_mem_reg <= spi_mem_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            blk_reg     <= (rd_next || wr_next) ? arg_next : 32'd0;
            bb_sel_reg  <= bb_sel_next;
            unk_reg     <= unk_next;
        end
    end

    logic [7:0] spi_out, buffer_byte;

    // buffer bytes come straight from the memory output register
    assign spi_out     = spi_mem_reg ? mem_q_reg : spi_reg;
    assign buffer_byte = bb_sel_reg ? mem_q_reg : 8'h00;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, unk_reg, buffer_byte, blk_reg, wr_reg, rd_reg, spi_out};

`ifndef SYNTHESIS
    a_pend_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        crc_pend_reg |-> $past(s_accept))
        else $error("crc pending without a preceding transfer");

    a_rd_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && rd_reg) |-> (spi_reg == TOKEN_START && !wr_reg))
        else $error("read request without start token");

    a_unknown_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && unk_next) |=> (state_reg == $past(state_reg)))
        else $error("unknown command left idle");
`endif

endmodule
